FILE: hdl/dmht_pkg.sv
// Shared types and constants for the direct-mapped hash table.
package dmht_pkg;

   localparam int unsigned DATA_WIDTH = 32;
   localparam int unsigned CSR_INDEX_WIDTH = 8;
   localparam int unsigned CSR_DATA_WIDTH = 11;
   localparam int unsigned SIZE_REG_WIDTH = 11;
   localparam int unsigned SLOT_OUT_WIDTH = 10;
   localparam int unsigned COUNT_OUT_WIDTH = 11;
   localparam int unsigned HASH_WIDTH = 32;

   localparam logic [SIZE_REG_WIDTH-1:0] TABLE_SIZE_RESET = 11'd1024;

   localparam logic [1:0] OP_PUT    = 2'd0;
   localparam logic [1:0] OP_GET    = 2'd1;
   localparam logic [1:0] OP_DELETE = 2'd2;
   localparam logic [1:0] OP_CLEAR  = 2'd3;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_COLLISION = 2'd1;
   localparam logic [1:0] ST_NULL      = 2'd2;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TABLE_SIZE     = 8'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_REPLACE_ENABLE = 8'd1;

   typedef struct packed {
      logic [1:0]            operation;
      logic [7:0]            key_byte;
      logic                  key_last;
      logic [DATA_WIDTH-1:0] data_in;
   } req_type;

   typedef struct packed {
      logic [1:0]                 status;
      logic [DATA_WIDTH-1:0]      data_out;
      logic [SLOT_OUT_WIDTH-1:0]  slot_index;
      logic [COUNT_OUT_WIDTH-1:0] occupied_count;
   } rsp_type;

endpackage

FILE: hdl/dmht_hash.sv
// One-at-a-time key hash: per-byte mix register and finishing logic.
module dmht_hash (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               upd,
   input  logic [7:0]                         key_byte,
   input  logic                               key_last,
   output logic [dmht_pkg::HASH_WIDTH-1:0]    fin_hash
);

   logic [dmht_pkg::HASH_WIDTH-1:0] running_ff;
   logic [dmht_pkg::HASH_WIDTH-1:0] mixed_ff;
   logic [dmht_pkg::HASH_WIDTH-1:0] mixed_in;

   function automatic logic [dmht_pkg::HASH_WIDTH-1:0] mix_byte(
      input logic [dmht_pkg::HASH_WIDTH-1:0] h,
      input logic [7:0]                      b
   );
      logic [dmht_pkg::HASH_WIDTH-1:0] t;
      t = h + {24'd0, b};
      t = t + (t << 10);
      t = t ^ (t >> 6);
      return t;
   endfunction

   function automatic logic [dmht_pkg::HASH_WIDTH-1:0] finish_hash(
      input logic [dmht_pkg::HASH_WIDTH-1:0] h
   );
      logic [dmht_pkg::HASH_WIDTH-1:0] t;
      t = h + (h << 3);
      t = t ^ (t >> 11);
      t = t + (t << 15);
      return t;
   endfunction

   assign mixed_in = mix_byte(running_ff, key_byte);
   assign fin_hash = finish_hash(mixed_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff <= '0;
      end else if (upd) begin
         running_ff <= key_last ? '0 : mixed_in;
      end
   end

   always_ff @(posedge clock) begin
      if (upd && key_last) begin
         mixed_ff <= mixed_in;
      end
   end

endmodule

FILE: hdl/dmht_mod.sv
// Restoring remainder unit: one dividend bit per cycle.
module dmht_mod #(
   parameter int unsigned DIVW = 11,
   parameter int unsigned NUMW = 32
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   input  logic [NUMW-1:0] dividend,
   input  logic [DIVW-1:0] divisor,
   output logic            done,
   output logic [DIVW-1:0] rem
);

   localparam int unsigned CW = $clog2(NUMW);

   logic [NUMW-1:0] num_ff;
   logic [DIVW-1:0] div_ff;
   logic [DIVW-1:0] rem_ff;
   logic [CW-1:0]   cnt_ff;
   logic            busy_ff;
   logic            done_ff;
   logic [DIVW:0]   cand;
   logic [DIVW:0]   diff;
   logic [DIVW-1:0] rem_in;

   always_comb begin
      cand = {rem_ff, num_ff[NUMW-1]};
      diff = cand - {1'b0, div_ff};
      rem_in = (cand >= {1'b0, div_ff}) ? diff[DIVW-1:0] : cand[DIVW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CW'(NUMW - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         num_ff <= dividend;
         div_ff <= divisor;
         rem_ff <= '0;
      end else if (busy_ff) begin
         num_ff <= num_ff << 1;
         rem_ff <= rem_in;
      end
   end

   assign done = done_ff;
   assign rem  = rem_ff;

endmodule

FILE: hdl/direct_mapped_hash_table.sv
// Direct-mapped hash table keyed by byte strings: sequencer, slot store, registers.
//
//   channel | ports                               | role
//   req     | req_valid, req_ready, req_word      | key byte, operation, data in
//   rsp     | rsp_valid, rsp_ready, rsp_word      | one word per last key byte
//   csr     | csr_valid, csr_ready, csr_index/data| table_size, replace_enable
//
// A non-last key byte only updates the hash mix register. A last byte runs: hash
// finish, 32 steps of the remainder unit, slot read and update.
// Clear then sweeps the store, one slot a cycle.
// After reset the store is swept the same way, req_ready low.
// A waiting rsp word stalls only the update of the next last byte.
module direct_mapped_hash_table #(
   parameter int unsigned TABLE_DEPTH = 1024
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   output logic                                     req_ready,
   input  dmht_pkg::req_type                        req_word,
   output logic                                     rsp_valid,
   input  logic                                     rsp_ready,
   output dmht_pkg::rsp_type                        rsp_word,
   input  logic                                     csr_valid,
   output logic                                     csr_ready,
   input  logic [dmht_pkg::CSR_INDEX_WIDTH-1:0]     csr_index,
   input  logic [dmht_pkg::CSR_DATA_WIDTH-1:0]      csr_data
);

   localparam int unsigned AW   = $clog2(TABLE_DEPTH);
   localparam int unsigned DIVW = $clog2(TABLE_DEPTH + 1);
   localparam int unsigned DW   = dmht_pkg::DATA_WIDTH;

   typedef enum logic [2:0] {
      S_WIPE,
      S_IDLE,
      S_FIN,
      S_DIV,
      S_READ,
      S_ACT
   } state_type;

   state_type state_ff;

   logic [dmht_pkg::SIZE_REG_WIDTH-1:0] size_ff;
   logic                                replace_ff;
   logic [1:0]                          op_ff;
   logic [DW-1:0]                       data_ff;
   logic [AW-1:0]                       slot_ff;
   logic [AW-1:0]                       wipe_ff;
   logic [DIVW-1:0]                     occ_ff;
   logic [DIVW-1:0]                     occ_in;
   logic [DW-1:0]                       rd_ff;
   logic                                rsp_valid_ff;
   dmht_pkg::rsp_type                   rsp_ff;

   logic [DW-1:0] mem [TABLE_DEPTH];

   logic                               req_fire;
   logic                               act_fire;
   logic [dmht_pkg::HASH_WIDTH-1:0]    fin_hash;
   logic                               mod_start;
   logic                               mod_done;
   logic [DIVW-1:0]                    mod_rem;
   logic [DIVW-1:0]                    size_eff;
   logic                               mem_we;
   logic [AW-1:0]                      mem_wa;
   logic [DW-1:0]                      mem_wd;
   logic                               act_we;
   logic [DW-1:0]                      act_wd;
   logic [1:0]                         act_status;
   logic [DW-1:0]                      act_result;

   assign req_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign act_fire  = (state_ff == S_ACT) && (!rsp_valid_ff || rsp_ready);
   assign mod_start = (state_ff == S_FIN);

   always_comb begin
      if (size_ff == '0) begin
         size_eff = DIVW'(1);
      end else if (32'(size_ff) > 32'(TABLE_DEPTH)) begin
         size_eff = DIVW'(TABLE_DEPTH);
      end else begin
         size_eff = DIVW'(size_ff);
      end
   end

   dmht_hash u_hash (
      .clock    (clock),
      .reset    (reset),
      .upd      (req_fire),
      .key_byte (req_word.key_byte),
      .key_last (req_word.key_last),
      .fin_hash (fin_hash)
   );

   dmht_mod #(
      .DIVW (DIVW),
      .NUMW (dmht_pkg::HASH_WIDTH)
   ) u_mod (
      .clock    (clock),
      .reset    (reset),
      .start    (mod_start),
      .dividend (fin_hash),
      .divisor  (size_eff),
      .done     (mod_done),
      .rem      (mod_rem)
   );

   always_comb begin
      act_we     = 1'b0;
      act_wd     = '0;
      act_status = dmht_pkg::ST_OK;
      act_result = '0;
      occ_in     = occ_ff;
      case (op_ff)
         dmht_pkg::OP_PUT: begin
            if (data_ff == '0) begin
               act_status = dmht_pkg::ST_NULL;
            end else if (rd_ff != '0 && !replace_ff) begin
               act_status = dmht_pkg::ST_COLLISION;
            end else begin
               act_result = rd_ff;
               act_we     = 1'b1;
               act_wd     = data_ff;
               if (rd_ff == '0) begin
                  occ_in = occ_ff + 1'b1;
               end
            end
         end
         dmht_pkg::OP_GET: begin
            act_result = rd_ff;
         end
         dmht_pkg::OP_DELETE: begin
            if (rd_ff != '0) begin
               act_we = 1'b1;
               occ_in = occ_ff - 1'b1;
            end
         end
         default: begin
            occ_in = '0;
         end
      endcase
   end

   always_comb begin
      if (state_ff == S_WIPE) begin
         mem_we = 1'b1;
         mem_wa = wipe_ff;
         mem_wd = '0;
      end else begin
         mem_we = act_fire && act_we;
         mem_wa = slot_ff;
         mem_wd = act_wd;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      rd_ff <= mem[slot_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff    <= dmht_pkg::TABLE_SIZE_RESET;
         replace_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            dmht_pkg::CSR_TABLE_SIZE:     size_ff    <= csr_data;
            dmht_pkg::CSR_REPLACE_ENABLE: replace_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_WIPE;
         wipe_ff      <= '0;
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready && !act_fire) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_WIPE: begin
               if (wipe_ff == AW'(TABLE_DEPTH - 1)) begin
                  wipe_ff  <= '0;
                  state_ff <= S_IDLE;
               end else begin
                  wipe_ff <= wipe_ff + 1'b1;
               end
            end
            S_IDLE: begin
               if (req_fire && req_word.key_last) begin
                  op_ff    <= req_word.operation;
                  data_ff  <= req_word.data_in;
                  state_ff <= S_FIN;
               end
            end
            S_FIN: begin
               state_ff <= S_DIV;
            end
            S_DIV: begin
               if (mod_done) begin
                  slot_ff  <= AW'(mod_rem);
                  state_ff <= S_READ;
               end
            end
            S_READ: begin
               state_ff <= S_ACT;
            end
            S_ACT: begin
               if (act_fire) begin
                  occ_ff                <= occ_in;
                  rsp_valid_ff          <= 1'b1;
                  rsp_ff.status         <= act_status;
                  rsp_ff.data_out       <= act_result;
                  rsp_ff.slot_index     <= dmht_pkg::SLOT_OUT_WIDTH'(slot_ff);
                  rsp_ff.occupied_count <= dmht_pkg::COUNT_OUT_WIDTH'(occ_in);
                  state_ff <= (op_ff == dmht_pkg::OP_CLEAR) ? S_WIPE : S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      32'(occ_ff) <= 32'(TABLE_DEPTH))
      else $error("occupied count above table depth");

   a_mod_done_in_div: assert property (@(posedge clock) disable iff (reset)
      mod_done |-> state_ff == S_DIV)
      else $error("remainder done outside division");

   a_clear_zero: assert property (@(posedge clock) disable iff (reset)
      act_fire && op_ff == dmht_pkg::OP_CLEAR |=>
         rsp_ff.occupied_count == '0 && state_ff == S_WIPE)
      else $error("clear did not zero count or start sweep");

   a_put_count: assert property (@(posedge clock) disable iff (reset)
      act_fire && op_ff == dmht_pkg::OP_PUT && data_ff != '0 && rd_ff == '0 |=>
         occ_ff == $past(occ_ff) + 1'b1)
      else $error("put to empty slot did not count up");

endmodule
